// ===== rtl/vas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared widths, transaction types, function codes and the cell command and
// search token types used by the voice cells and the top level.
// ----------------------------------------------------------------------------
package vas_pkg;

    // Fixed widths of the transaction fields and internal indexes.
    localparam int FUNC_W       = 2;
    localparam int VOICE_IDX_W  = 3;
    localparam int VCOUNT_W     = 4;
    localparam int STAMP_W      = 32;

    // Voice indexes inside the chain cover up to sixteen voices.
    localparam int VOICES_LIMIT = 16;
    localparam int VIDX_W       = 4;
    localparam int VCNT_W       = 5;

    // Default pool size and the reset value of the voice count register.
    localparam int                  VOICES_DEFAULT = 8;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = 4'd8;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_PLAY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;

    // Request transaction.
    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [VOICE_IDX_W-1:0] voice_index;
        logic                   start_ok;
    } vas_req_t;

    // Response transaction.
    typedef struct packed {
        logic [VOICE_IDX_W-1:0] granted_voice;
        logic                   granted;
        logic                   stolen;
    } vas_rsp_t;

    // Command broadcast to every voice cell.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_GRANT,
        CMD_FREE,
        CMD_END,
        CMD_STOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [VIDX_W-1:0]  voice;
        logic [STAMP_W-1:0] stamp;
    } cell_cmd_t;

    // Search token that walks the chain one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               found_free;
        logic               have_act;
        logic [VIDX_W-1:0]  best_idx;
        logic [STAMP_W-1:0] best_stamp;
    } scan_tok_t;

endpackage

// ===== rtl/vas_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice cell
// Holds the active flag and age stamp of one voice, applies broadcast
// commands, and refines the search token before passing it to the next cell.
// ----------------------------------------------------------------------------
module vas_cell
    import vas_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [VCNT_W-1:0] n_eff,
    input  cell_cmd_t         cmd,
    input  scan_tok_t         tok_in,
    output scan_tok_t         tok_out
);

    logic               active_reg;
    logic               active_next;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;
    scan_tok_t          tok_reg;
    scan_tok_t          tok_next;
    logic               in_range;
    logic               hit;

    assign in_range = VCNT_W'(IDX) < n_eff;
    assign hit      = cmd.voice == VIDX_W'(IDX);

    // Apply the broadcast command to this voice.
    always_comb
    begin
        active_next = active_reg;
        stamp_next  = stamp_reg;
        case (cmd.kind)
            CMD_GRANT:
            begin
                if (hit)
                begin
                    active_next = 1'b1;
                    stamp_next  = cmd.stamp;
                end
            end
            CMD_FREE:
            begin
                if (hit)
                begin
                    active_next = 1'b0;
                end
            end
            CMD_END:
            begin
                if (hit && active_reg)
                begin
                    active_next = 1'b0;
                    stamp_next  = '0;
                end
            end
            CMD_STOP:
            begin
                if (in_range)
                begin
                    active_next = 1'b0;
                    stamp_next  = '0;
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    // A free voice ends the search; otherwise keep the oldest active voice.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && in_range && !tok_in.found_free)
        begin
            if (!active_reg)
            begin
                tok_next.found_free = 1'b1;
                tok_next.best_idx   = VIDX_W'(IDX);
            end
            else if (!tok_in.have_act || (stamp_reg < tok_in.best_stamp))
            begin
                tok_next.have_act   = 1'b1;
                tok_next.best_idx   = VIDX_W'(IDX);
                tok_next.best_stamp = stamp_reg;
            end
        end
    end

    // Voice state and the token stage toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            stamp_reg  <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            stamp_reg  <= stamp_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/voice_allocator_oldest_steal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator with oldest-voice stealing
// Hands out playback voices, frees ended voices and stops all voices.
// ----------------------------------------------------------------------------
// Usage:
//   req (req_valid/req_ready) carries one request transaction: play, voice
//   ended or stop all. Each request yields exactly one response transaction
//   on rsp (rsp_valid/rsp_ready).
//   cfg (cfg_valid/cfg_ready, cfg_data) writes the voice count; it is always
//   ready and should be written only while the block is idle.
// Sequencing:
//   A play request sends a search token down a chain of MAX_VOICES voice
//   cells, one cell per cycle; the sequencer registers the chosen voice and
//   moves to the commit state, which registers the response. Other requests
//   go straight from acceptance to the commit state. One request is in
//   flight at a time: the next is taken once the response is registered.
// Reset:
//   All voices inactive with zero stamps, stamp counter zero, voice count 8.
// Stall:
//   A response waits in the output register while rsp_ready is low; the next
//   request is still accepted and its work is held back until that register
//   frees up.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal
    import vas_pkg::*;
#(
    parameter int MAX_VOICES = VOICES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  vas_req_t            req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output vas_rsp_t            rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [VCOUNT_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    vas_req_t            item_reg;
    vas_req_t            item_next;
    logic [VIDX_W-1:0]   choice_reg;
    logic [VIDX_W-1:0]   choice_next;
    logic                stolen_reg;
    logic                stolen_next;
    vas_rsp_t            rsp_reg;
    vas_rsp_t            rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [STAMP_W-1:0]  next_stamp_reg;
    logic [STAMP_W-1:0]  next_stamp_next;
    logic [VCOUNT_W-1:0] voice_count_reg;
    logic [VCNT_W-1:0]   n_eff;
    logic                accept;
    logic                out_free;
    cell_cmd_t           cmd;
    scan_tok_t           tok [MAX_VOICES+1];
    logic [MAX_VOICES-1:0] tok_valid_vec;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_count_reg <= VCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            voice_count_reg <= cfg_data;
        end
    end

    // Effective voice count, clamped to one through MAX_VOICES.
    always_comb
    begin
        if (voice_count_reg == '0)
        begin
            n_eff = VCNT_W'(1);
        end
        else if (VCNT_W'(voice_count_reg) > VCNT_W'(MAX_VOICES))
        begin
            n_eff = VCNT_W'(MAX_VOICES);
        end
        else
        begin
            n_eff = VCNT_W'(voice_count_reg);
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Seed token enters the first cell when a play request is accepted.
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = accept && (req.func == FUNC_PLAY);
    end

    // Chain of voice cells.
    for (genvar i = 0; i < MAX_VOICES; i++)
    begin : g_cell
        vas_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .n_eff   (n_eff),
            .cmd     (cmd),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
        assign tok_valid_vec[i] = tok[i+1].valid;
    end

    // Sequencer: accept, scan for a play request, then commit the command and the response.
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        choice_next     = choice_reg;
        stolen_next     = stolen_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        next_stamp_next = next_stamp_reg;
        cmd             = '{kind: CMD_NONE, voice: '0, stamp: next_stamp_reg};

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req;
                    state_next = (req.func == FUNC_PLAY) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (tok[MAX_VOICES].valid)
                begin
                    choice_next = tok[MAX_VOICES].best_idx;
                    stolen_next = !tok[MAX_VOICES].found_free;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_next       = '0;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (item_reg.func == FUNC_PLAY)
                    begin
                        cmd.voice              = choice_reg;
                        rsp_next.granted_voice = VOICE_IDX_W'(choice_reg);
                        rsp_next.granted       = item_reg.start_ok;
                        rsp_next.stolen        = stolen_reg;
                        if (item_reg.start_ok)
                        begin
                            cmd.kind        = CMD_GRANT;
                            next_stamp_next = next_stamp_reg + STAMP_W'(1);
                        end
                        else
                        begin
                            cmd.kind = CMD_FREE;
                        end
                    end
                    else if (item_reg.func == FUNC_END)
                    begin
                        cmd.voice = VIDX_W'(item_reg.voice_index);
                        if (VCNT_W'(item_reg.voice_index) < n_eff)
                        begin
                            cmd.kind = CMD_END;
                        end
                    end
                    else if (item_reg.func == FUNC_STOP)
                    begin
                        cmd.kind = CMD_STOP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            choice_reg     <= '0;
            stolen_reg     <= 1'b0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            next_stamp_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            choice_reg     <= choice_next;
            stolen_reg     <= stolen_next;
            rsp_reg        <= rsp_next;
            rsp_valid_reg  <= rsp_valid_next;
            next_stamp_reg <= next_stamp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Only one search token travels the chain at a time.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one search token in the voice chain");

    // The token leaves the chain only while the sequencer waits for it.
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX_VOICES].valid |-> (state_reg == S_SCAN))
        else $error("search token finished outside the scan state");

    // A new response only comes out of the commit state.
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("response raised outside the commit state");

    // Every granted voice consumes exactly one stamp.
    a_stamp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.kind == CMD_GRANT) |=> (next_stamp_reg == $past(next_stamp_reg) + 32'd1))
        else $error("stamp counter did not advance on a grant");

endmodule

// ===== tb/voice_allocator_oldest_steal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator checker
// Watches the request, response and voice count channels of the allocator,
// keeps its own copy of the voice pool, predicts the response of every
// accepted request and compares each accepted response field by field.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_checker
    import vas_pkg::*;
#(
    parameter int MAX_VOICES = VOICES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  vas_req_t            req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  vas_rsp_t            rsp,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [VCOUNT_W-1:0] cfg_data,
    output int                  outstanding,
    output int                  mismatches
);

    // Shadow copy of the voice pool and the voice count register.
    logic                voice_on [MAX_VOICES];
    logic [STAMP_W-1:0]  voice_age [MAX_VOICES];
    logic [STAMP_W-1:0]  stamp_counter;
    logic [VCOUNT_W-1:0] voice_count;

    // Responses predicted but not yet seen, oldest first.
    vas_rsp_t            expected_grants[$];

    // One line per mismatch, and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] allocator mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Apply one request to the shadow pool and work out its response.
    task automatic predict_allocation(input vas_req_t item, output vas_rsp_t result);
        int unsigned in_use;
        int unsigned pick;
        bit          found;
        bit          was_on;
        if (voice_count == '0)
            in_use = 1;
        else if (voice_count > MAX_VOICES)
            in_use = MAX_VOICES;
        else
            in_use = voice_count;
        result = '0;
        case (item.func)
            FUNC_PLAY:
            begin
                found = 1'b0;
                pick  = 0;
                // The lowest free voice wins.
                for (int v = 0; v < in_use; v++)
                begin
                    if (!found && !voice_on[v])
                    begin
                        pick  = v;
                        found = 1'b1;
                    end
                end
                // Otherwise steal the smallest raw stamp, lowest index on a tie.
                if (!found)
                begin
                    for (int v = 0; v < in_use; v++)
                    begin
                        if (voice_on[v] && (!found || voice_age[v] < voice_age[pick]))
                        begin
                            pick  = v;
                            found = 1'b1;
                        end
                    end
                end
                was_on = voice_on[pick];
                if (item.start_ok)
                begin
                    voice_on[pick]  = 1'b1;
                    voice_age[pick] = stamp_counter;
                    stamp_counter   = stamp_counter + STAMP_W'(1);
                end
                else
                begin
                    // A failed start leaves the voice free with its old stamp.
                    voice_on[pick] = 1'b0;
                end
                result.granted_voice = VOICE_IDX_W'(pick);
                result.granted       = item.start_ok;
                result.stolen        = was_on;
            end
            FUNC_END:
            begin
                if (item.voice_index < in_use && voice_on[item.voice_index])
                begin
                    voice_on[item.voice_index]  = 1'b0;
                    voice_age[item.voice_index] = '0;
                end
            end
            FUNC_STOP:
            begin
                for (int v = 0; v < in_use; v++)
                begin
                    voice_on[v]  = 1'b0;
                    voice_age[v] = '0;
                end
            end
            default:
            begin
                // Undefined function: nothing changes and the response is zero.
            end
        endcase
    endtask

    // Sample every channel at the clock edge where its transaction completes.
    always @(posedge clk or negedge rst_n)
    begin
        vas_rsp_t want;
        vas_rsp_t calc;
        if (!rst_n)
        begin
            for (int v = 0; v < MAX_VOICES; v++)
            begin
                voice_on[v]  = 1'b0;
                voice_age[v] = '0;
            end
            stamp_counter = '0;
            voice_count   = VCOUNT_RESET;
            expected_grants.delete();
            outstanding   = 0;
        end
        else
        begin
            // A response is always checked against the oldest prediction.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    report_mismatch($sformatf("response %0d/%0b/%0b with none outstanding",
                        rsp.granted_voice, rsp.granted, rsp.stolen));
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp.granted_voice !== want.granted_voice)
                        report_mismatch($sformatf("granted_voice got %0d expected %0d",
                            rsp.granted_voice, want.granted_voice));
                    if (rsp.granted !== want.granted)
                        report_mismatch($sformatf("granted got %0b expected %0b",
                            rsp.granted, want.granted));
                    if (rsp.stolen !== want.stolen)
                        report_mismatch($sformatf("stolen got %0b expected %0b",
                            rsp.stolen, want.stolen));
                end
            end
            if (cfg_valid && cfg_ready)
                voice_count = cfg_data;
            if (req_valid && req_ready)
            begin
                predict_allocation(req, calc);
                expected_grants.push_back(calc);
            end
            outstanding = expected_grants.size();
        end
    end

endmodule

// ===== tb/voice_allocator_oldest_steal_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives directed and random request sequences through the allocator across
// a sweep of voice counts, with random idling on both channels, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_tb;
    import vas_pkg::*;

    localparam int                MAX_VOICES = VOICES_DEFAULT;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
    localparam int                PHASES     = 12;
    localparam int                PHASE_LEN  = 75;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    vas_req_t            req;
    logic                rsp_valid;
    logic                rsp_ready;
    vas_rsp_t            rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [VCOUNT_W-1:0] cfg_data;
    logic                steady;
    int                  outstanding;
    int                  mismatches;

    voice_allocator_oldest_steal #(
        .MAX_VOICES (MAX_VOICES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    voice_allocator_oldest_steal_checker #(
        .MAX_VOICES (MAX_VOICES)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The response side stalls on about 18 percent of cycles unless held steady.
    always @(posedge clk)
    begin
        rsp_ready <= steady || ($urandom_range(0, 99) >= 18);
    end

    // Hard stop if the run hangs.
    initial
    begin
        #5000000;
        $display("voice_allocator_oldest_steal regression: fail");
        $finish;
    end

    function automatic vas_req_t make_item(input logic [FUNC_W-1:0] func,
                                           input int unsigned idx, input bit ok);
        vas_req_t item;
        item.func        = func;
        item.voice_index = VOICE_IDX_W'(idx);
        item.start_ok    = ok;
        return item;
    endfunction

    // Offer one request transaction, with a random gap first; returns on the
    // clock edge that accepts it.
    task automatic send_item(input vas_req_t item);
        while (!steady && $urandom_range(0, 99) < 18)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(negedge clk);
        while (!req_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold off requests until every predicted response has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Write the voice count with the block idle.
    task automatic write_voice_count(input logic [VCOUNT_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                  sent;
        int                  roll;
        logic [VCOUNT_W-1:0] count_value;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        steady    = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Failed start on an empty pool, then fill all eight voices.
        send_item(make_item(FUNC_PLAY, 0, 1'b0));
        for (int v = 0; v < 8; v++)
            send_item(make_item(FUNC_PLAY, v, 1'b1));
        // Full pool: steal the oldest, then a failed start that steals and frees.
        send_item(make_item(FUNC_PLAY, 0, 1'b1));
        send_item(make_item(FUNC_PLAY, 0, 1'b0));
        send_item(make_item(FUNC_PLAY, 0, 1'b1));
        // End an active voice, end it again while inactive, undefined function.
        send_item(make_item(FUNC_END, 3, 1'b0));
        send_item(make_item(FUNC_END, 3, 1'b1));
        send_item(make_item(FUNC_UNDEF, 7, 1'b1));
        send_item(make_item(FUNC_PLAY, 5, 1'b1));
        send_item(make_item(FUNC_STOP, 2, 1'b1));

        // Count above the maximum is clamped; two voices with an ended voice out
        // of range.
        write_voice_count(4'd15);
        write_voice_count(4'd2);
        send_item(make_item(FUNC_PLAY, 0, 1'b1));
        send_item(make_item(FUNC_PLAY, 0, 1'b1));
        send_item(make_item(FUNC_PLAY, 0, 1'b1));
        send_item(make_item(FUNC_END, 5, 1'b1));
        // Zero acts as one voice; stop-all leaves voice one alone.
        write_voice_count(4'd0);
        send_item(make_item(FUNC_PLAY, 0, 1'b1));
        send_item(make_item(FUNC_STOP, 0, 1'b0));
        // Back to eight: voice one has kept its state.
        write_voice_count(4'd8);
        send_item(make_item(FUNC_PLAY, 0, 1'b1));
        send_item(make_item(FUNC_PLAY, 0, 1'b1));

        // Random phases across a sweep of voice counts.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       count_value = 4'd8;
                1:       count_value = 4'd1;
                2:       count_value = 4'd0;
                3:       count_value = 4'd15;
                4:       count_value = 4'd3;
                default: count_value = VCOUNT_W'($urandom_range(0, 15));
            endcase
            write_voice_count(count_value);
            // One phase runs with no idling on either side.
            steady <= (p == 6);
            sent = 0;
            while (sent < PHASE_LEN)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    send_item(make_item(FUNC_PLAY, $urandom_range(0, 7),
                                        $urandom_range(0, 99) < 85));
                    sent++;
                end
                else if (roll < 88)
                begin
                    send_item(make_item(FUNC_END, $urandom_range(0, 7),
                                        $urandom_range(0, 1)));
                    sent++;
                end
                else if (roll < 96)
                begin
                    send_item(make_item(FUNC_STOP, $urandom_range(0, 7),
                                        $urandom_range(0, 1)));
                    sent++;
                end
                else
                begin
                    send_item(make_item(FUNC_UNDEF, $urandom_range(0, 7),
                                        $urandom_range(0, 1)));
                end
                // Now and then let the pipeline run dry.
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        // Wait out the last responses and a little beyond.
        drain();
        steady <= 1'b0;
        repeat (MAX_VOICES + 4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("voice_allocator_oldest_steal regression: pass");
        else
            $display("voice_allocator_oldest_steal regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vas_pkg.sv
rtl/vas_cell.sv
rtl/voice_allocator_oldest_steal.sv
tb/voice_allocator_oldest_steal_checker.sv
tb/voice_allocator_oldest_steal_tb.sv
